### rtl/core/x86_bcd_pkg.sv
// Request and result types and function codes for the x86 decimal-adjust unit.
package x86_bcd_pkg;

    localparam logic [2:0] FUNC_DAA = 3'd0;
    localparam logic [2:0] FUNC_DAS = 3'd1;
    localparam logic [2:0] FUNC_AAA = 3'd2;
    localparam logic [2:0] FUNC_AAS = 3'd3;
    localparam logic [2:0] FUNC_AAD = 3'd4;
    localparam logic [2:0] FUNC_AAM = 3'd5;

    localparam logic [7:0]  ADJ_HI    = 8'h60;
    localparam logic [7:0]  ADJ_LO    = 8'h06;
    localparam logic [7:0]  BCD_MAX   = 8'h99;
    localparam logic [3:0]  NIB_MAX   = 4'h9;
    localparam logic [15:0] ADJ_AX    = 16'h0106;
    localparam logic [7:0]  AAA_SF_LO = 8'h7a;
    localparam logic [7:0]  AAA_SF_HI = 8'hf9;
    localparam logic [7:0]  AAS_SF_HI = 8'h85;
    localparam logic [7:0]  AAS_OF_LO = 8'h80;
    localparam logic [7:0]  DAS_CF_LO = 8'h05;
    localparam logic [3:0]  AAA_OF_HI = 4'h7;
    localparam logic [7:0]  NIB_MASK  = 8'h0f;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] al_in;
        logic [7:0] ah_in;
        logic       carry_in;
        logic       aux_carry_in;
        logic       overflow_in;
        logic [7:0] base;
    } t_request;

    typedef struct packed {
        logic [7:0] al_out;
        logic [7:0] ah_out;
        logic       carry_out;
        logic       aux_carry_out;
        logic       overflow_out;
        logic       sign_out;
        logic       zero_out;
        logic       parity_out;
        logic       divide_error;
    } t_result;

    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] quo;
    } t_div;

endpackage

### rtl/core/x86_bcd_adjust_unit.sv
// Three-stage pipelined x86 DAA/DAS/AAA/AAS/AAD/AAM execution unit.
// An accepted request passes through stage registers A, B and C before its o_done strobe.
// Throughput: one request per cycle; busy stays low, the AAM divide runs
// as an 8-step restoring divider spread over the three stages (3, 3, 2 steps).
// Reset (synchronous, active low) clears all stage valid bits; in-flight
// requests are dropped and no result is strobed until new requests arrive.
module x86_bcd_adjust_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  x86_bcd_pkg::t_request i_req,
    output logic                 o_done,
    output x86_bcd_pkg::t_result  o_res
);
    import x86_bcd_pkg::*;

    function automatic t_div div_step(input t_div d, input logic [7:0] b);
        logic [8:0] t;
        t_div       r;
        t = {d.rem, d.quo[7]};
        r.quo = {d.quo[6:0], 1'b0};
        if (t >= {1'b0, b}) begin
            r.rem    = 8'(t - {1'b0, b});
            r.quo[0] = 1'b1;
        end else begin
            r.rem = t[7:0];
        end
        return r;
    endfunction

    logic       r_a_vld, r_b_vld, r_c_vld;
    logic       n_a_vld, n_b_vld, n_c_vld;
    logic       r_a_aam, r_b_aam;
    t_result    r_a_res, r_b_res, r_c_res;
    t_result    n_a_res, n_c_res;
    t_div       r_a_div, r_b_div;
    t_div       n_a_div, n_b_div, n_c_div;
    logic [7:0] r_a_base, r_b_base;

    logic        low_big, hi_big, nib_big;
    logic [7:0]  al, ah, t8;
    logic [15:0] ax;
    logic [7:0]  prod;

    assign busy = 1'b0;
    assign n_a_vld = start & ~busy;
    assign n_b_vld = r_a_vld;
    assign n_c_vld = r_b_vld;

    always_comb begin
        al      = i_req.al_in;
        ah      = i_req.ah_in;
        nib_big = al[3:0] > NIB_MAX;
        low_big = nib_big | i_req.aux_carry_in;
        hi_big  = (al > BCD_MAX) | i_req.carry_in;
        t8      = al;
        ax      = {ah, al};
        prod    = 8'(ah * i_req.base);

        n_a_res.al_out        = al;
        n_a_res.ah_out        = ah;
        n_a_res.carry_out     = i_req.carry_in;
        n_a_res.aux_carry_out = i_req.aux_carry_in;
        n_a_res.overflow_out  = i_req.overflow_in;
        n_a_res.sign_out      = al[7];
        n_a_res.zero_out      = al == 8'h00;
        n_a_res.parity_out    = ~^al;
        n_a_res.divide_error  = 1'b0;

        unique case (i_req.func)
            FUNC_DAA: begin
                if (hi_big) t8 = t8 + ADJ_HI;
                if (low_big) t8 = t8 + ADJ_LO;
                n_a_res.al_out        = t8;
                n_a_res.carry_out     = hi_big;
                n_a_res.aux_carry_out = low_big;
                n_a_res.sign_out      = t8[7];
                n_a_res.zero_out      = t8 == 8'h00;
                n_a_res.parity_out    = ~^t8;
            end
            FUNC_DAS: begin
                if (hi_big) begin
                    t8 = t8 - ADJ_HI;
                    n_a_res.carry_out = 1'b1;
                end else begin
                    n_a_res.carry_out = low_big & (al <= DAS_CF_LO);
                end
                if (low_big) t8 = t8 - ADJ_LO;
                n_a_res.al_out        = t8;
                n_a_res.aux_carry_out = low_big;
                n_a_res.overflow_out  = al[7] & ~t8[7];
                n_a_res.sign_out      = t8[7];
                n_a_res.zero_out      = t8 == 8'h00;
                n_a_res.parity_out    = ~^t8;
            end
            FUNC_AAA: begin
                if (low_big) ax = ax + ADJ_AX;
                n_a_res.sign_out      = (al >= AAA_SF_LO) & (al <= AAA_SF_HI);
                n_a_res.overflow_out  = nib_big & (al[7:4] == AAA_OF_HI);
                n_a_res.carry_out     = low_big;
                n_a_res.aux_carry_out = low_big;
                n_a_res.zero_out      = nib_big ? (ax[7:0] == 8'h00)
                                      : (~i_req.aux_carry_in & (al == 8'h00));
                n_a_res.parity_out    = ~^ax[7:0];
                n_a_res.al_out        = ax[7:0] & NIB_MASK;
                n_a_res.ah_out        = ax[15:8];
            end
            FUNC_AAS: begin
                if (low_big) ax = ax - ADJ_AX;
                if (nib_big) begin
                    n_a_res.sign_out = al > AAS_SF_HI;
                end else if (i_req.aux_carry_in) begin
                    n_a_res.sign_out = (al < ADJ_LO) | (al > AAS_SF_HI);
                end else begin
                    n_a_res.sign_out = al[7];
                end
                n_a_res.overflow_out  = ~nib_big & i_req.aux_carry_in
                                      & (al >= AAS_OF_LO) & (al <= AAS_SF_HI);
                n_a_res.carry_out     = low_big;
                n_a_res.aux_carry_out = low_big;
                n_a_res.zero_out      = ax[7:0] == 8'h00;
                n_a_res.parity_out    = ~^ax[7:0];
                n_a_res.al_out        = ax[7:0] & NIB_MASK;
                n_a_res.ah_out        = ax[15:8];
            end
            FUNC_AAD: begin
                t8 = prod + al;
                n_a_res.al_out        = t8;
                n_a_res.ah_out        = 8'h00;
                n_a_res.carry_out     = 1'b0;
                n_a_res.aux_carry_out = 1'b0;
                n_a_res.overflow_out  = 1'b0;
                n_a_res.sign_out      = t8[7];
                n_a_res.zero_out      = t8 == 8'h00;
                n_a_res.parity_out    = ~^t8;
            end
            FUNC_AAM: begin
                n_a_res.sign_out     = 1'b0;
                n_a_res.zero_out     = 1'b0;
                n_a_res.parity_out   = 1'b0;
                n_a_res.divide_error = i_req.base == 8'h00;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        t_div d;
        d.rem = 8'h00;
        d.quo = i_req.al_in;
        d = div_step(d, i_req.base);
        d = div_step(d, i_req.base);
        n_a_div = div_step(d, i_req.base);
    end

    always_comb begin
        t_div d;
        d = div_step(r_a_div, r_a_base);
        d = div_step(d, r_a_base);
        n_b_div = div_step(d, r_a_base);
    end

    always_comb begin
        n_c_div = div_step(div_step(r_b_div, r_b_base), r_b_base);
        n_c_res = r_b_res;
        if (r_b_aam && !r_b_res.divide_error) begin
            n_c_res.al_out        = n_c_div.rem;
            n_c_res.ah_out        = n_c_div.quo;
            n_c_res.carry_out     = 1'b0;
            n_c_res.aux_carry_out = 1'b0;
            n_c_res.overflow_out  = 1'b0;
            n_c_res.sign_out      = n_c_div.rem[7];
            n_c_res.zero_out      = n_c_div.rem == 8'h00;
            n_c_res.parity_out    = ~^n_c_div.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
            r_c_vld <= n_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_res  <= n_a_res;
        r_a_div  <= n_a_div;
        r_a_base <= i_req.base;
        r_a_aam  <= i_req.func == FUNC_AAM;
        r_b_res  <= r_a_res;
        r_b_div  <= n_b_div;
        r_b_base <= r_a_base;
        r_b_aam  <= r_a_aam;
        r_c_res  <= n_c_res;
    end

    assign o_done = r_c_vld;
    assign o_res  = r_c_res;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("accepted request did not complete in three cycles");

    a_de_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.divide_error) |->
            (!o_res.sign_out && !o_res.zero_out && !o_res.parity_out))
        else $error("divide error result carries status flags");

    a_de_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.divide_error) |-> ($past(r_b_base) == 8'h00))
        else $error("divide error raised with nonzero base");

    a_aam_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(r_b_aam) && !o_res.divide_error) |->
            (!o_res.carry_out && !o_res.aux_carry_out && !o_res.overflow_out))
        else $error("aam result left carry or overflow set");

endmodule
